[rtl/mgg_pkg.sv]
package mgg_pkg;

    localparam int YearW = 12;
    localparam int MonthW = 4;
    localparam int WdayW = 3;
    localparam int DaysW = 5;
    localparam int SumW = 13;
    localparam int QW = 6;
    localparam int AddrW = 4;
    localparam int DataW = 32;

    localparam logic [SumW-1:0] YearBias = 13'd400;
    localparam logic [10:0] Recip25 = 11'd1311;
    localparam int RecipShift = 15;

    localparam logic [1:0] RegWeekStart = 2'd0;
    localparam logic [1:0] RegYearMin = 2'd1;
    localparam logic [1:0] RegYearMax = 2'd2;

    localparam logic [MonthW-1:0] MonthFeb = 4'd2;
    localparam logic [MonthW-1:0] MonthMar = 4'd3;
    localparam logic [MonthW-1:0] MonthDec = 4'd12;

    typedef struct packed {
        logic [WdayW-1:0] week_start;
        logic [YearW-1:0] year_min;
        logic [YearW-1:0] year_max;
    } cfg_t;

    typedef struct packed {
        logic              ok;
        logic [MonthW-1:0] month;
        logic [YearW-1:0]  year;
        logic [SumW-1:0]   yy;
        logic [QW-1:0]     q100;
        logic [QW-1:0]     qy;
    } s1_t;

    typedef struct packed {
        logic              ok;
        logic [WdayW-1:0]  wday;
        logic [DaysW-1:0]  days;
    } s3_t;

    function automatic logic [2:0] month_offset(input logic [MonthW-1:0] m);
        logic [2:0] r;
        case (m)
            4'd1:    r = 3'd0;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd2;
            4'd4:    r = 3'd5;
            4'd5:    r = 3'd0;
            4'd6:    r = 3'd3;
            4'd7:    r = 3'd5;
            4'd8:    r = 3'd1;
            4'd9:    r = 3'd4;
            4'd10:   r = 3'd6;
            4'd11:   r = 3'd2;
            4'd12:   r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [DaysW-1:0] month_len(input logic [MonthW-1:0] m);
        logic [DaysW-1:0] r;
        case (m)
            4'd2:    r = 5'd28;
            4'd4:    r = 5'd30;
            4'd6:    r = 5'd30;
            4'd9:    r = 5'd30;
            4'd11:   r = 5'd30;
            default: r = 5'd31;
        endcase
        return r;
    endfunction

    // 8 == 1 mod 7, so octal digits fold
    function automatic logic [WdayW-1:0] mod7(input logic [SumW-1:0] x);
        logic [4:0] s;
        logic [3:0] t;
        s = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[11:9]) + 5'(x[12]);
        t = 4'(s[2:0]) + 4'(s[4:3]);
        if (t >= 4'd7) begin
            t = t - 4'd7;
        end
        return t[2:0];
    endfunction

endpackage

[rtl/month_grid_geometry.sv]
// An accepted input word passes the year, week and grid stage registers to m_axis.
// Throughput: one word per cycle while m_axis accepts; every stage refills as soon
// as it drains, so a stall on m_axis only backs up stages that hold a word.
// Reset: synchronous, active-low aresetn clears all stage valid bits and loads
// week_start 0, year_min 1970, year_max 2105.
module month_grid_geometry
    import mgg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [15:0]      s_axis_tdata,  // [11:0] year, [15:12] month
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // [2:0] first_weekday, [7:3] month_days,
                                            // [10:8] lead_cells, [13:11] row_count
    output logic             m_axis_tuser,  // [0] valid_res
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready
);

    cfg_t cfg;
    logic s1_valid;
    logic s1_load;
    s1_t s1_data;
    logic s3_valid;
    logic s3_load;
    s3_t s3_data;

    mgg_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mgg_year_stage u_year (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .year      (s_axis_tdata[11:0]),
        .month     (s_axis_tdata[15:12]),
        .cfg       (cfg),
        .out_valid (s1_valid),
        .out_load  (s1_load),
        .out_data  (s1_data)
    );

    mgg_week_stage u_week (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_load),
        .in_data   (s1_data),
        .out_valid (s3_valid),
        .out_load  (s3_load),
        .out_data  (s3_data)
    );

    mgg_grid_stage u_grid (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s3_valid),
        .in_ready      (s3_load),
        .in_data       (s3_data),
        .week_start    (cfg.week_start),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    a_days_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[7:3] >= 5'd28 && m_axis_tdata[7:3] <= 5'd31)
        else $error("month length out of range");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 16'd0)
        else $error("invalid result carries nonzero fields");

    a_grid_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[2:0] != 3'd7 && m_axis_tdata[10:8] != 3'd7
            && m_axis_tdata[13:11] >= 3'd4 && m_axis_tdata[13:11] <= 3'd6)
        else $error("weekday, lead or row count out of range");

    a_six_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser && m_axis_tdata[13:11] == 3'd6 |->
            m_axis_tdata[10:8] >= 3'd5)
        else $error("six rows with too few lead cells");

endmodule

[rtl/mgg_cfg_regs.sv]
module mgg_cfg_regs
    import mgg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    logic wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign idx = paddr[3:2];
    assign wr_en = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.week_start <= '0;
            cfg_reg.year_min <= 12'd1970;
            cfg_reg.year_max <= 12'd2105;
        end else if (wr_en) begin
            case (idx)
                RegWeekStart: cfg_reg.week_start <= pwdata[WdayW-1:0];
                RegYearMin:   cfg_reg.year_min <= pwdata[YearW-1:0];
                RegYearMax:   cfg_reg.year_max <= pwdata[YearW-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            RegWeekStart: prdata = DataW'(cfg_reg.week_start);
            RegYearMin:   prdata = DataW'(cfg_reg.year_min);
            RegYearMax:   prdata = DataW'(cfg_reg.year_max);
            default:      prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[rtl/mgg_year_stage.sv]
module mgg_year_stage
    import mgg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [YearW-1:0]  year,
    input  logic [MonthW-1:0] month,
    input  cfg_t              cfg,
    output logic              out_valid,
    input  logic              out_load,
    output s1_t               out_data
);

    logic valid_reg;
    s1_t data_reg;
    s1_t data_next;
    logic load;
    logic [10:0] q4;
    logic [21:0] prod_q;
    logic [20:0] prod_y;

    assign load = !valid_reg || out_load;
    assign in_ready = load;

    always_comb begin
        data_next.ok = (month != '0) && (month <= MonthDec)
                       && (year >= cfg.year_min) && (year <= cfg.year_max);
        data_next.month = month;
        data_next.year = year;
        // shift by 400 years (whole weeks); Jan/Feb count in the prior year
        data_next.yy = SumW'(year) + YearBias - SumW'(month < MonthMar);
        // floor(x/100) == floor(floor(x/4)/25), reciprocal multiply
        q4 = data_next.yy[12:2];
        prod_q = q4 * Recip25;
        data_next.q100 = prod_q[RecipShift +: QW];
        prod_y = year[11:2] * Recip25;
        data_next.qy = prod_y[RecipShift +: QW];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

[rtl/mgg_week_stage.sv]
module mgg_week_stage
    import mgg_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  s1_t  in_data,
    output logic out_valid,
    input  logic out_load,
    output s3_t  out_data
);

    logic v2_reg;
    logic v3_reg;
    logic ok2_reg;
    logic [SumW-1:0] sum2_reg;
    logic [SumW-1:0] sum2_next;
    logic [DaysW-1:0] days2_reg;
    logic [DaysW-1:0] days2_next;
    s3_t s3_reg;
    logic load2;
    logic load3;
    logic leap;
    logic [SumW-1:0] cent;

    assign load3 = !v3_reg || out_load;
    assign load2 = !v2_reg || load3;
    assign in_ready = load2;

    always_comb begin
        cent = SumW'(in_data.qy) * 13'd100;
        leap = (in_data.year[1:0] == 2'b00)
               && ((SumW'(in_data.year) != cent) || (in_data.qy[1:0] == 2'b00));
        days2_next = month_len(in_data.month)
                     + DaysW'((in_data.month == MonthFeb) && leap);
        sum2_next = in_data.yy + SumW'(in_data.yy[12:2]) - SumW'(in_data.q100)
                    + SumW'(in_data.q100[QW-1:2]) + SumW'(month_offset(in_data.month))
                    + 13'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (load2) begin
                v2_reg <= in_valid;
            end
            if (load3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load2) begin
            ok2_reg <= in_data.ok;
            sum2_reg <= sum2_next;
            days2_reg <= days2_next;
        end
        if (load3) begin
            s3_reg.ok <= ok2_reg;
            s3_reg.wday <= mod7(sum2_reg);
            s3_reg.days <= days2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_data = s3_reg;

endmodule

[rtl/mgg_grid_stage.sv]
module mgg_grid_stage
    import mgg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  s3_t               in_data,
    input  logic [WdayW-1:0]  week_start,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,
    output logic              m_axis_tuser
);

    logic valid_reg;
    logic [15:0] data_reg;
    logic [15:0] data_next;
    logic user_reg;
    logic load;
    logic [WdayW-1:0] ws;
    logic [3:0] t;
    logic [WdayW-1:0] lead;
    logic [5:0] cells;
    logic [2:0] rows;

    assign load = !valid_reg || m_axis_tready;
    assign in_ready = load;

    always_comb begin
        ws = (week_start == 3'd7) ? 3'd0 : week_start;
        t = 4'(in_data.wday) + 4'd7 - 4'(ws);
        if (t >= 4'd7) begin
            t = t - 4'd7;
        end
        lead = t[2:0];
        cells = 6'(lead) + 6'(in_data.days);
        // cells is 28..37 for a real month
        if (cells > 6'd35) begin
            rows = 3'd6;
        end else if (cells > 6'd28) begin
            rows = 3'd5;
        end else begin
            rows = 3'd4;
        end
        if (in_data.ok) begin
            data_next = {2'b00, rows, lead, in_data.days, in_data.wday};
        end else begin
            data_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
            user_reg <= in_data.ok;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata = data_reg;
    assign m_axis_tuser = user_reg;

endmodule
